FILE: src/ehc_pkg.sv
// Shared types and constants for the Ethernet header classifier.
// Used by ehc_capture, ehc_classify and ethernet_header_classifier_top; no dependencies.
package ehc_pkg;

  // The byte counter stops at this count. Bytes after that point are not
  // counted and are not captured.
  localparam int unsigned MaxFrameBytes = 16384;
  localparam int unsigned CountLimit    = (MaxFrameBytes < 32767) ? MaxFrameBytes : 32767;
  localparam int unsigned LenW          = 15;
  localparam logic [LenW-1:0] CountLimitC = LenW'(CountLimit);

  localparam logic [7:0]  EthHeader  = 8'd14;
  localparam logic [5:0]  Ipv6Header = 6'd40;
  localparam logic [5:0]  ArpHeader  = 6'd28;
  localparam logic [5:0]  SmallL4    = 6'd8;

  localparam logic [15:0] TypeIpv4   = 16'h0800;
  localparam logic [15:0] TypeIpv6   = 16'h86DD;
  localparam logic [15:0] TypeArp    = 16'h0806;

  localparam logic [7:0]  NoProto    = 8'hFF;
  localparam logic [7:0]  ProtoIcmp  = 8'd1;
  localparam logic [7:0]  ProtoTcp   = 8'd6;
  localparam logic [7:0]  ProtoUdp   = 8'd17;
  localparam logic [7:0]  ProtoIcmp6 = 8'd58;

  localparam logic [15:0] DnsDefault = 16'd53;
  localparam logic [13:0] PayMax     = 14'h3FFF;

  // Byte positions of the fixed header fields within the frame.
  localparam logic [LenW-1:0] IdxTypeHi    = 15'd12;
  localparam logic [LenW-1:0] IdxTypeLo    = 15'd13;
  localparam logic [LenW-1:0] IdxIhl       = 15'd14;
  localparam logic [LenW-1:0] IdxV6Next    = 15'd20;
  localparam logic [LenW-1:0] IdxV4Proto   = 15'd23;

  typedef enum logic [3:0] {
    ClsEth    = 4'd0,
    ClsIpv4   = 4'd1,
    ClsIpv6   = 4'd2,
    ClsArp    = 4'd3,
    ClsIcmp   = 4'd4,
    ClsTcp    = 4'd5,
    ClsUdp    = 4'd6,
    ClsDns    = 4'd7,
    ClsIcmpv6 = 4'd8
  } class_e;

  // Header fields of one finished frame, handed from capture to classification.
  typedef struct packed {
    logic [LenW-1:0] len;
    logic [15:0]     ether_type;
    logic [5:0]      net_hdr;
    logic [7:0]      proto;
    logic [15:0]     source_port;
    logic [15:0]     dest_port;
    logic [5:0]      tcp_hdr;
  } snap_t;

  typedef struct packed {
    class_e          cls;
    logic [5:0]      l3_size;
    logic [5:0]      l4_size;
    logic [13:0]     payload_length;
    logic [LenW-1:0] frame_length;
    logic            truncated;
  } result_t;

endpackage

FILE: src/ehc_capture.sv
// Per-byte header field capture for the Ethernet header classifier.
// Depends on ehc_pkg; produces one registered snapshot per frame.
module ehc_capture (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           byte_valid_i,
  output logic           byte_ready_o,
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  output ehc_pkg::snap_t snap_o,
  output logic           snap_valid_o,
  input  logic           snap_ready_i
);

  logic [ehc_pkg::LenW-1:0] count_q, count_d;
  logic [15:0] et_q, et_d;
  logic [5:0]  nhb_q, nhb_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] src_q, src_d;
  logic [15:0] dst_q, dst_d;
  logic [5:0]  tcp_q, tcp_d;
  logic [7:0]  hold_q, hold_d;
  logic        snap_valid_q;
  ehc_pkg::snap_t snap_q;
  logic        accept;
  logic [7:0]  toff;
  logic [ehc_pkg::LenW-1:0] tx;

  assign byte_ready_o = !snap_valid_q || snap_ready_i;
  assign accept       = byte_valid_i && byte_ready_o;

  always_comb begin
    count_d = count_q;
    et_d    = et_q;
    nhb_d   = nhb_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    tcp_d   = tcp_q;
    hold_d  = hold_q;
    toff    = ehc_pkg::EthHeader + {2'b00, nhb_q};
    tx      = {{(ehc_pkg::LenW-8){1'b0}}, toff};
    if (count_q < ehc_pkg::CountLimitC) begin
      count_d = count_q + 1'b1;
      if (count_q == ehc_pkg::IdxTypeHi) begin
        hold_d = byte_i;
      end
      if (count_q == ehc_pkg::IdxTypeLo) begin
        et_d = {hold_q, byte_i};
        if (et_d == ehc_pkg::TypeIpv6) begin
          nhb_d = ehc_pkg::Ipv6Header;
        end else if (et_d == ehc_pkg::TypeArp) begin
          nhb_d = ehc_pkg::ArpHeader;
        end
      end
      if (et_d == ehc_pkg::TypeIpv4 && count_q == ehc_pkg::IdxIhl) begin
        nhb_d = {byte_i[3:0], 2'b00};
      end
      if (et_d == ehc_pkg::TypeIpv4 && count_q == ehc_pkg::IdxV4Proto) begin
        proto_d = byte_i;
      end
      if (et_d == ehc_pkg::TypeIpv6 && count_q == ehc_pkg::IdxV6Next) begin
        proto_d = byte_i;
      end
      // The transport offset follows a header length captured in this same step.
      toff = ehc_pkg::EthHeader + {2'b00, nhb_d};
      tx   = {{(ehc_pkg::LenW-8){1'b0}}, toff};
      if (et_d == ehc_pkg::TypeIpv4 || et_d == ehc_pkg::TypeIpv6) begin
        if (count_q == tx || count_q == tx + 15'd2) begin
          hold_d = byte_i;
        end
        if (count_q == tx + 15'd1) begin
          src_d = {hold_q, byte_i};
        end
        if (count_q == tx + 15'd3) begin
          dst_d = {hold_q, byte_i};
        end
        if (count_q == tx + 15'd12) begin
          tcp_d = {byte_i[7:4], 2'b00};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      et_q    <= '0;
      nhb_q   <= '0;
      proto_q <= ehc_pkg::NoProto;
      src_q   <= '0;
      dst_q   <= '0;
      tcp_q   <= '0;
      hold_q  <= '0;
    end else if (accept && last_i) begin
      count_q <= '0;
      et_q    <= '0;
      nhb_q   <= '0;
      proto_q <= ehc_pkg::NoProto;
      src_q   <= '0;
      dst_q   <= '0;
      tcp_q   <= '0;
      hold_q  <= '0;
    end else if (accept) begin
      count_q <= count_d;
      et_q    <= et_d;
      nhb_q   <= nhb_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      tcp_q   <= tcp_d;
      hold_q  <= hold_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (accept && last_i) begin
      snap_valid_q <= 1'b1;
    end else if (snap_ready_i) begin
      snap_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_i) begin
      snap_q.len         <= count_d;
      snap_q.ether_type  <= et_d;
      snap_q.net_hdr     <= nhb_d;
      snap_q.proto       <= proto_d;
      snap_q.source_port <= src_d;
      snap_q.dest_port   <= dst_d;
      snap_q.tcp_hdr     <= tcp_d;
    end
  end

  assign snap_o       = snap_q;
  assign snap_valid_o = snap_valid_q;

endmodule

FILE: src/ehc_classify.sv
// Frame classification and header size arithmetic with a result register.
// Depends on ehc_pkg; consumes snapshots from ehc_capture.
module ehc_classify (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ehc_pkg::snap_t   snap_i,
  input  logic             snap_valid_i,
  output logic             snap_ready_o,
  input  logic [15:0]      dns_port_i,
  output ehc_pkg::result_t res_o,
  output logic             res_valid_o,
  input  logic             res_ready_i
);

  ehc_pkg::result_t res_d, res_q;
  logic             res_valid_q;
  logic [7:0]       toff;
  logic [ehc_pkg::LenW-1:0] tx;
  logic [7:0]       hdrs;
  logic [ehc_pkg::LenW-1:0] pay_full;
  logic             ports_ok;
  logic             port_hit;

  assign snap_ready_o = !res_valid_q || res_ready_i;

  always_comb begin
    res_d              = '0;
    res_d.cls          = ehc_pkg::ClsEth;
    res_d.frame_length = snap_i.len;
    res_d.truncated    = snap_i.len < {7'd0, ehc_pkg::EthHeader};
    toff     = ehc_pkg::EthHeader + {2'b00, snap_i.net_hdr};
    tx       = {{(ehc_pkg::LenW-8){1'b0}}, toff};
    ports_ok = snap_i.len >= tx + 15'd4;
    port_hit = ports_ok &&
               (snap_i.source_port == dns_port_i || snap_i.dest_port == dns_port_i);
    if (snap_i.ether_type == ehc_pkg::TypeIpv4 ||
        snap_i.ether_type == ehc_pkg::TypeIpv6) begin
      if (snap_i.ether_type == ehc_pkg::TypeIpv4) begin
        res_d.cls = ehc_pkg::ClsIpv4;
        if (snap_i.len < 15'd24) begin
          res_d.truncated = 1'b1;
        end
      end else begin
        res_d.cls = ehc_pkg::ClsIpv6;
        if (snap_i.len < 15'd21) begin
          res_d.truncated = 1'b1;
        end
      end
      res_d.l3_size = snap_i.net_hdr;
      unique case (snap_i.proto)
        ehc_pkg::ProtoIcmp: begin
          res_d.cls     = ehc_pkg::ClsIcmp;
          res_d.l4_size = ehc_pkg::SmallL4;
        end
        ehc_pkg::ProtoTcp: begin
          res_d.cls     = port_hit ? ehc_pkg::ClsDns : ehc_pkg::ClsTcp;
          res_d.l4_size = snap_i.tcp_hdr;
          if (!ports_ok || snap_i.len < tx + 15'd13) begin
            res_d.truncated = 1'b1;
          end
        end
        ehc_pkg::ProtoUdp: begin
          res_d.cls     = port_hit ? ehc_pkg::ClsDns : ehc_pkg::ClsUdp;
          res_d.l4_size = ehc_pkg::SmallL4;
          if (!ports_ok) begin
            res_d.truncated = 1'b1;
          end
        end
        ehc_pkg::ProtoIcmp6: begin
          res_d.cls     = ehc_pkg::ClsIcmpv6;
          res_d.l4_size = ehc_pkg::SmallL4;
        end
        default: begin
        end
      endcase
    end else if (snap_i.ether_type == ehc_pkg::TypeArp) begin
      res_d.cls     = ehc_pkg::ClsArp;
      res_d.l3_size = ehc_pkg::ArpHeader;
    end
    hdrs     = ehc_pkg::EthHeader + {2'b00, res_d.l3_size} + {2'b00, res_d.l4_size};
    pay_full = snap_i.len - {7'd0, hdrs};
    if (snap_i.len <= {7'd0, hdrs}) begin
      res_d.payload_length = '0;
    end else if (pay_full > {1'b0, ehc_pkg::PayMax}) begin
      res_d.payload_length = ehc_pkg::PayMax;
    end else begin
      res_d.payload_length = pay_full[13:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (snap_ready_o) begin
      res_valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_valid_i && snap_ready_o) begin
      res_q <= res_d;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

FILE: src/ethernet_header_classifier_top.sv
// Top level of the Ethernet header classifier: stream ports and the DNS port register.
// Depends on ehc_pkg, ehc_capture and ehc_classify.
//
// The block takes an Ethernet II frame one byte per transaction on the slave
// stream, starting with the destination MAC, with tlast on the final byte.
// It accepts a byte in every cycle unless the result path backs up, so it keeps
// up with a byte-wide link at line rate. A single capture stage updates the
// header fields (EtherType, IPv4 header length, protocol or next header,
// transport ports and TCP data offset) as each byte goes by; IPv6 and ARP use
// fixed header sizes. On the last byte the fields are frozen into a snapshot
// register and the frame state clears, so the next frame may start in the
// following cycle. The classification stage turns the snapshot into one
// result transaction on the master stream, held in its result register:
// class, L3 and L4 header sizes, payload length, frame length and a truncated
// flag. Each stage holds one frame result; the input stalls only when both
// are full and the consumer holds m_axis_tready low. Frames longer than 16384
// bytes report 16384 and ignore the extra bytes. The DNS port (reset 53) is
// written through the cfg channel, which is always ready, and must only
// change while no frame is in flight.
module ethernet_header_classifier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input byte stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic        s_axis_tlast,   // last_byte
  // Result stream, one transaction per frame.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [5:0] l3_size, [11:6] l4_size,
                                      // [25:12] payload_length, [40:26] frame_length,
                                      // [47:41] zero
  output logic [4:0]  m_axis_tuser,   // [3:0] protocol_class, [4] truncated
  // DNS port register write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0]      dns_port_q;
  ehc_pkg::snap_t   snap;
  logic             snap_valid;
  logic             snap_ready;
  ehc_pkg::result_t res;

  // The register is always writable; the user must write it only between frames.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dns_port_q <= ehc_pkg::DnsDefault;
    end else if (cfg_valid_i) begin
      dns_port_q <= cfg_data_i;
    end
  end

  ehc_capture u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .snap_o       (snap),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready)
  );

  ehc_classify u_classify (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_i       (snap),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .dns_port_i   (dns_port_q),
    .res_o        (res),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {7'd0, res.frame_length, res.payload_length,
                         res.l4_size, res.l3_size};
  assign m_axis_tuser = {res.truncated, res.cls};

  // A finished frame always lands in the snapshot register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> snap_valid)
    else $error("last byte accepted without a snapshot");

  // Every reported frame holds at least the byte that ended it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.frame_length != '0))
    else $error("result with zero frame length");

  // Frames that are not IP or ARP carry no header sizes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.cls == ehc_pkg::ClsEth) |->
      (res.l3_size == '0 && res.l4_size == '0))
    else $error("plain Ethernet class with nonzero header size");

  // ARP never reports a transport header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.cls == ehc_pkg::ClsArp) |->
      (res.l3_size == ehc_pkg::ArpHeader && res.l4_size == '0))
    else $error("ARP result with wrong header sizes");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for ethernet_header_classifier_top: streams frames byte by byte and
// checks each frame result against a cycle-free behavioral predictor kept inside the bench.
// Depends on ehc_pkg and the classifier RTL; needs nothing else.
module tb;
  import ehc_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] frame_byte
  logic        s_axis_tlast;   // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [5:0] l3_size, [11:6] l4_size, [25:12] payload_length,
                               // [40:26] frame_length, [47:41] zero
  logic [4:0]  m_axis_tuser;   // [3:0] protocol_class, [4] truncated
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  ethernet_header_classifier_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: a mirror of the per-frame header fields plus the DNS port register.
  int unsigned byte_count;
  logic [15:0] ether_type;
  logic [5:0]  net_hdr_bytes;
  logic [7:0]  transport_proto;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [5:0]  tcp_hdr_bytes;
  logic [7:0]  high_byte;
  logic [15:0] dns_port_setting;

  result_t     expected_results[$];
  logic [7:0]  frame_bytes[$];
  int          error_count = 0;
  int unsigned sent_bytes = 0;
  int unsigned sent_frames = 0;
  int unsigned idle_cycles = 0;
  bit          in_idle_en = 1'b1;
  bit          out_idle_en = 1'b1;

  function automatic void clear_frame_state();
    byte_count      = 0;
    ether_type      = '0;
    net_hdr_bytes   = '0;
    transport_proto = NoProto;
    source_port     = '0;
    dest_port       = '0;
    tcp_hdr_bytes   = '0;
    high_byte       = '0;
  endfunction

  // Picks header fields out of the stream by their byte position. The transport offset
  // follows the network header size as soon as that is known, even if it overlaps.
  function automatic void capture_byte(int unsigned idx, logic [7:0] b);
    int unsigned t;
    if (idx == 12) high_byte = b;
    if (idx == 13) begin
      ether_type = {high_byte, b};
      if (ether_type == TypeIpv6) net_hdr_bytes = Ipv6Header;
      else if (ether_type == TypeArp) net_hdr_bytes = ArpHeader;
    end
    if (ether_type == TypeIpv4 && idx == 14) net_hdr_bytes = {b[3:0], 2'b00};
    if (ether_type == TypeIpv4 && idx == 23) transport_proto = b;
    if (ether_type == TypeIpv6 && idx == 20) transport_proto = b;
    if (ether_type != TypeIpv4 && ether_type != TypeIpv6) return;
    t = int'(EthHeader) + net_hdr_bytes;
    if (idx == t || idx == t + 2) high_byte = b;
    if (idx == t + 1) source_port = {high_byte, b};
    if (idx == t + 3) dest_port = {high_byte, b};
    if (idx == t + 12) tcp_hdr_bytes = {b[7:4], 2'b00};
  endfunction

  // Advances the predictor by one accepted byte; on the final byte it queues the result.
  function automatic void classify_byte(logic [7:0] b, logic last);
    result_t     r;
    int unsigned len, t, hdrs, pay;
    logic        ports_ok, port_hit;
    if (byte_count < CountLimit) begin
      capture_byte(byte_count, b);
      byte_count++;
    end
    if (!last) return;
    len = byte_count;
    r = '0;
    r.cls = ClsEth;
    r.truncated = (len < 14);
    if (ether_type == TypeIpv4 || ether_type == TypeIpv6) begin
      if (ether_type == TypeIpv4) begin
        r.cls = ClsIpv4;
        if (len < 24) r.truncated = 1'b1;
      end else begin
        r.cls = ClsIpv6;
        if (len < 21) r.truncated = 1'b1;
      end
      r.l3_size = net_hdr_bytes;
      t = int'(EthHeader) + net_hdr_bytes;
      ports_ok = (len >= t + 4);
      port_hit = ports_ok &&
                 (source_port == dns_port_setting || dest_port == dns_port_setting);
      case (transport_proto)
        ProtoIcmp: begin
          r.cls = ClsIcmp;
          r.l4_size = SmallL4;
        end
        ProtoTcp: begin
          r.cls = ClsTcp;
          r.l4_size = tcp_hdr_bytes;
          if (!ports_ok || len < t + 13) r.truncated = 1'b1;
          if (port_hit) r.cls = ClsDns;
        end
        ProtoUdp: begin
          r.cls = ClsUdp;
          r.l4_size = SmallL4;
          if (!ports_ok) r.truncated = 1'b1;
          if (port_hit) r.cls = ClsDns;
        end
        ProtoIcmp6: begin
          r.cls = ClsIcmpv6;
          r.l4_size = SmallL4;
        end
        default: ;
      endcase
    end else if (ether_type == TypeArp) begin
      r.cls = ClsArp;
      r.l3_size = ArpHeader;
    end
    hdrs = int'(EthHeader) + r.l3_size + r.l4_size;
    pay = (len > hdrs) ? len - hdrs : 0;
    if (pay > int'(PayMax)) pay = PayMax;
    r.payload_length = pay[13:0];
    r.frame_length = len[LenW-1:0];
    expected_results.push_back(r);
    clear_frame_state();
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Every byte transaction accepted by the block advances the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) classify_byte(s_axis_tdata, s_axis_tlast);
  end

  // Every result transaction is matched against the oldest pending prediction.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction arrived with no frame pending");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("protocol_class", want.cls, m_axis_tuser[3:0]);
        check_field("truncated", want.truncated, m_axis_tuser[4]);
        check_field("l3_size", want.l3_size, m_axis_tdata[5:0]);
        check_field("l4_size", want.l4_size, m_axis_tdata[11:6]);
        check_field("payload_length", want.payload_length, m_axis_tdata[25:12]);
        check_field("frame_length", want.frame_length, m_axis_tdata[40:26]);
      end
    end
  end

  // Ends a hung run: no transaction on any channel for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result consumer: before each result it may hold tready low for a random stall.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = out_idle_en ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Sends one byte; called and returning at a falling edge. With no gap the valid stays
  // high straight into the next transaction.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = in_idle_en ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    sent_frames++;
  endtask

  function automatic void put(int unsigned idx, logic [7:0] v);
    if (idx < frame_bytes.size()) frame_bytes[idx] = v;
  endfunction

  // Random bytes with the requested header fields laid over them. Ports go in first so
  // that a small IHL overlapping them still leaves the IHL and protocol bytes as asked.
  task automatic make_frame(input int unsigned len, input logic [15:0] et,
                            input logic [3:0] ihl, input logic [7:0] proto,
                            input logic [15:0] sp, input logic [15:0] dp,
                            input logic [3:0] doff);
    int unsigned t;
    frame_bytes.delete();
    for (int unsigned i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
    put(12, et[15:8]);
    put(13, et[7:0]);
    if (et == TypeIpv6) t = 14 + 40;
    else if (et == TypeArp) t = 14 + 28;
    else t = 14 + ihl * 4;
    put(t, sp[15:8]);
    put(t + 1, sp[7:0]);
    put(t + 2, dp[15:8]);
    put(t + 3, dp[7:0]);
    put(t + 12, {doff, 4'($urandom)});
    if (et == TypeIpv4) begin
      put(14, {4'h4, ihl});
      put(23, proto);
    end
    if (et == TypeIpv6) begin
      put(14, 8'h60);
      put(20, proto);
    end
  endtask

  // Drains the pipeline so the DNS port register may be written safely.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_dns_port(input logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    dns_port_setting = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // The register comes out of reset at 53, so port 53 must already classify as DNS.
  task automatic test_default_dns_port();
    make_frame(50, TypeIpv4, 5, ProtoUdp, 16'd4000, 16'd53, 5);
    send_frame();
    make_frame(100, TypeIpv6, 5, ProtoTcp, 16'd53, 16'd8080, 5);
    send_frame();
  endtask

  task automatic test_each_class();
    make_frame(64, 16'h1234, 5, ProtoTcp, 1, 2, 5);           // unknown EtherType
    send_frame();
    make_frame(60, TypeIpv4, 5, 8'd99, 1, 2, 5);              // IPv4, other transport
    send_frame();
    make_frame(70, TypeIpv6, 5, 8'd0, 1, 2, 5);               // IPv6, other transport
    send_frame();
    make_frame(42, TypeArp, 5, ProtoTcp, 1, 2, 5);
    send_frame();
    make_frame(50, TypeIpv4, 5, ProtoIcmp, 1, 2, 5);
    send_frame();
    make_frame(70, TypeIpv4, 5, ProtoTcp, 16'd80, 16'd1234, 5);
    send_frame();
    make_frame(80, TypeIpv6, 5, ProtoUdp, 16'd5000, 16'd6000, 5);
    send_frame();
    make_frame(70, TypeIpv6, 5, ProtoIcmp6, 1, 2, 5);
    send_frame();
    make_frame(70, TypeIpv6, 5, ProtoIcmp, 1, 2, 5);          // ICMP carried by IPv6
    send_frame();
    make_frame(60, TypeIpv4, 5, ProtoIcmp6, 1, 2, 5);         // ICMPv6 carried by IPv4
    send_frame();
    make_frame(140, TypeIpv4, 15, ProtoTcp, 7, 9, 15);        // largest header sizes
    send_frame();
    make_frame(60, TypeIpv4, 0, ProtoTcp, 7, 9, 5);           // transport overlapping IPv4
    send_frame();
    make_frame(60, TypeIpv4, 2, ProtoUdp, 7, 9, 5);
    send_frame();
  endtask

  // All-zero and all-one frames.
  task automatic test_byte_extremes();
    frame_bytes.delete();
    repeat (20) frame_bytes.push_back(8'h00);
    send_frame();
    frame_bytes.delete();
    repeat (20) frame_bytes.push_back(8'hFF);
    send_frame();
  endtask

  // Frames that end just before and just at each field that their class needs.
  task automatic test_short_frames();
    make_frame(1, TypeIpv4, 5, ProtoTcp, 1, 2, 5);
    send_frame();
    make_frame(13, TypeIpv4, 5, ProtoTcp, 1, 2, 5);
    send_frame();
    make_frame(14, TypeIpv4, 5, ProtoTcp, 1, 2, 5);
    send_frame();
    make_frame(15, TypeIpv4, 5, ProtoTcp, 1, 2, 5);
    send_frame();
    make_frame(23, TypeIpv4, 5, ProtoTcp, 1, 2, 5);
    send_frame();
    make_frame(24, TypeIpv4, 5, ProtoUdp, 1, 53, 5);
    send_frame();
    make_frame(20, TypeIpv6, 5, ProtoTcp, 1, 2, 5);
    send_frame();
    make_frame(21, TypeIpv6, 5, ProtoTcp, 1, 2, 5);
    send_frame();
    make_frame(37, TypeIpv4, 5, ProtoTcp, 1, 53, 5);          // destination port cut
    send_frame();
    make_frame(38, TypeIpv4, 5, ProtoTcp, 1, 53, 5);          // data offset missing
    send_frame();
    make_frame(46, TypeIpv4, 5, ProtoTcp, 1, 2, 5);
    send_frame();
    make_frame(47, TypeIpv4, 5, ProtoTcp, 1, 2, 5);
    send_frame();
    make_frame(54, TypeIpv4, 5, ProtoTcp, 1, 2, 5);           // headers only, no payload
    send_frame();
    make_frame(37, TypeIpv4, 5, ProtoUdp, 53, 2, 5);
    send_frame();
    make_frame(30, TypeArp, 5, ProtoUdp, 1, 2, 5);            // ARP shorter than its header
    send_frame();
  endtask

  // Zero must not match ports that were never received; the all-ones port must match.
  task automatic test_dns_port_register();
    wait_idle();
    write_dns_port(16'h0000);
    make_frame(36, TypeIpv4, 5, ProtoTcp, 0, 0, 5);
    send_frame();
    make_frame(50, TypeIpv4, 5, ProtoUdp, 16'd1000, 16'h0000, 5);
    send_frame();
    wait_idle();
    write_dns_port(16'hFFFF);
    make_frame(50, TypeIpv4, 5, ProtoUdp, 16'hFFFF, 16'd1000, 5);
    send_frame();
    make_frame(80, TypeIpv6, 5, ProtoTcp, 16'd1000, 16'hFFFF, 5);
    send_frame();
    make_frame(50, TypeIpv4, 5, ProtoUdp, 16'd53, 16'd1000, 5);
    send_frame();
  endtask

  // Mostly well-formed frames with random content, some cut short and some odd types.
  task automatic send_random_frame();
    int unsigned kind, len, l3, l4;
    logic [15:0] et, sp, dp;
    logic [3:0]  ihl, doff;
    logic [7:0]  proto;
    kind = $urandom_range(0, 99);
    if (kind < 40) et = TypeIpv4;
    else if (kind < 70) et = TypeIpv6;
    else if (kind < 80) et = TypeArp;
    else et = 16'($urandom);
    ihl  = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5;
    doff = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
    case ($urandom_range(0, 6))
      0:       proto = ProtoIcmp;
      1, 2:    proto = ProtoTcp;
      3, 4:    proto = ProtoUdp;
      5:       proto = ProtoIcmp6;
      default: proto = 8'($urandom);
    endcase
    sp = ($urandom_range(0, 3) == 0) ? dns_port_setting : 16'($urandom);
    dp = ($urandom_range(0, 3) == 0) ? dns_port_setting : 16'($urandom);
    if (et == TypeIpv6) l3 = 40;
    else if (et == TypeArp) l3 = 28;
    else if (et == TypeIpv4) l3 = ihl * 4;
    else l3 = 0;
    l4 = (proto == ProtoTcp) ? doff * 4 : 8;
    if ($urandom_range(0, 5) == 0) len = $urandom_range(1, 14 + l3 + l4 + 2);
    else len = 14 + l3 + l4 + $urandom_range(0, 24);
    in_idle_en  = ($urandom_range(0, 3) != 0);
    out_idle_en = ($urandom_range(0, 3) != 0);
    make_frame(len, et, ihl, proto, sp, dp, doff);
    send_frame();
  endtask

  // Four phases, each with its own DNS port setting, written while the block is idle.
  task automatic test_random_traffic();
    logic [15:0] settings[4];
    int unsigned byte_goal, frame_goal;
    settings = '{16'($urandom), 16'hFFFF, 16'h0000, DnsDefault};
    foreach (settings[p]) begin
      wait_idle();
      write_dns_port(settings[p]);
      byte_goal  = sent_bytes + 1;
      frame_goal = sent_frames + 1;
      while (sent_bytes < byte_goal || sent_frames < frame_goal) send_random_frame();
    end
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    dns_port_setting = DnsDefault;
    clear_frame_state();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_default_dns_port();
    test_each_class();
    test_byte_extremes();
    test_short_frames();
    test_dns_port_register();
    test_random_traffic();

    // Let the last results drain; the watchdog bounds this wait.
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/ehc_pkg.sv
src/ehc_capture.sv
src/ehc_classify.sv
src/ethernet_header_classifier_top.sv
tb/sv/tb.sv
